// ===== hdl/cbg_pkg.sv =====
// Shared types, constants and arithmetic helpers for the contact basis generator.
package cbg_pkg;

   localparam int ROOT_BITS = 16;   // bits of the scaled root, one per pipeline stage
   localparam int FRAC_BITS = 14;   // Q2.14 fraction
   localparam int ROOT_LAT  = ROOT_BITS;

   // Sideband that travels beside the root lanes
   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               br_x;    // |x| > |y| branch
      logic               neg_a;   // sign of first tangent component
      logic               neg_b;   // sign of tangent z component
      logic               degen;   // zero denominator
   } side_type;

   // One restoring step of the scaled root
   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] acc;
      logic [15:0] root;
   } root_type;

   // Try one root bit: keep it where (u + 2^k)^2 * s still fits under the target
   function automatic root_type root_step(input int k, input root_type cur,
                                          input logic [31:0] den);
      logic [63:0] term;
      root_type    nxt;
      term = (cur.acc << (k + 1)) + ({32'b0, den} << (2 * k));
      nxt  = cur;
      if (term <= cur.rem) begin
         nxt.rem  = cur.rem - term;
         nxt.acc  = cur.acc + ({32'b0, den} << k);
         nxt.root = cur.root | (16'd1 << k);
      end
      return nxt;
   endfunction

   // Q4.28 sum to Q2.14: nearest, ties away from zero, saturated
   function automatic logic [15:0] to_q14(input logic signed [32:0] v);
      logic [32:0] mag;
      logic [18:0] r;
      logic [15:0] res;
      mag = v[32] ? 33'(-v) : 33'(v);
      r   = 19'((mag + 33'd8192) >> FRAC_BITS);
      if (v[32]) begin
         if (r >= 19'd32768) begin
            res = 16'h8000;
         end else begin
            res = 16'(-r);
         end
      end else begin
         if (r > 19'd32767) begin
            res = 16'h7fff;
         end else begin
            res = r[15:0];
         end
      end
      return res;
   endfunction

endpackage

// ===== hdl/cbg_root_lane.sv =====
// Pipelined bit-per-stage root: largest u with u*u*den <= target.
module cbg_root_lane (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] target,
   input  logic [31:0] denom,
   output logic [15:0] root
);
   import cbg_pkg::*;

   root_type    stage_ff [0:ROOT_BITS-1];
   logic [31:0] den_ff   [0:ROOT_BITS-1];

   genvar i;
   generate
      for (i = 0; i < ROOT_BITS; i++) begin : g_stage
         root_type    cur;
         logic [31:0] den;
         root_type    stage_in;

         // Take the previous stage, or the lane input at the head
         if (i == 0) begin : g_head
            always_comb begin
               cur.rem  = target;
               cur.acc  = 64'd0;
               cur.root = 16'd0;
               den      = denom;
            end
         end else begin : g_body
            always_comb begin
               cur = stage_ff[i-1];
               den = den_ff[i-1];
            end
         end

         // Decide one root bit, most significant first
         always_comb begin
            stage_in = root_step(ROOT_BITS - 1 - i, cur, den);
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               stage_ff[i] <= stage_in;
               den_ff[i]   <= den;
            end
         end
      end
   endgenerate

   assign root = stage_ff[ROOT_BITS-1].root;

endmodule

// ===== hdl/contact_basis_generator.sv =====
// Throughput: one request per cycle unless a held result is refused; the
// 16-stage root pipeline, one bit a stage, sets the depth. The whole pipeline
// halts while a held result is refused.
// Reset: clears the stage valid bits only; data registers are not reset.
// Degenerate normals (zero denominator) give zero axes with rsp_tuser set.
module contact_basis_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // normal_x[15:0], normal_y[31:16], normal_z[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // tangent_x, tangent_y, tangent_z, bitangent_x,
                                    // bitangent_y, bitangent_z, 16 bits each from bit 0
   output logic        rsp_tuser    // degenerate
);
   import cbg_pkg::*;

   localparam int NSTAGE = 3 + ROOT_LAT + 4;

   logic              enable;
   logic [NSTAGE:1]   vld_ff;

   // Front stages
   side_type          sd1_ff, sd2_ff, sd3_ff;
   logic [15:0]       mag_a_ff, mag_b_ff;
   logic [30:0]       sq_a_ff, sq_b_ff;
   logic [31:0]       den_ff;
   logic [63:0]       tgt_a_ff, tgt_b_ff;
   side_type          sd1_in;
   side_type          sd3_in;
   logic [15:0]       mag_a_in, mag_b_in;

   // Root delay and back stages
   side_type          sdr_ff [0:ROOT_LAT-1];
   logic [15:0]       root_a, root_b;
   side_type          sd20_ff, sd21_ff, sd22_ff;
   logic signed [15:0] tan_a_ff, tan_b_ff, tan_a21_ff, tan_b21_ff, tan_a22_ff, tan_b22_ff;
   logic signed [15:0] tan_a_in, tan_b_in;
   logic signed [31:0] m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [32:0] b0_ff, b1_ff, b2_ff;
   logic [95:0]       out_data_ff;
   logic              out_degen_ff;

   // Advance everything unless the held result is refused
   assign enable     = !vld_ff[NSTAGE] || rsp_tready;
   assign req_tready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[NSTAGE-1:1], req_tvalid};
      end
   end

   // Stage 1: branch choice, magnitudes and signs
   always_comb begin
      logic signed [15:0] nx, ny, nz;
      logic [15:0]        ax, ay, az;
      nx = req_tdata[15:0];
      ny = req_tdata[31:16];
      nz = req_tdata[47:32];
      ax = nx[15] ? 16'(-nx) : 16'(nx);
      ay = ny[15] ? 16'(-ny) : 16'(ny);
      az = nz[15] ? 16'(-nz) : 16'(nz);
      sd1_in.nx    = nx;
      sd1_in.ny    = ny;
      sd1_in.nz    = nz;
      sd1_in.br_x  = ax > ay;
      sd1_in.degen = 1'b0;
      mag_a_in     = az;
      if (ax > ay) begin
         mag_b_in     = ax;
         sd1_in.neg_a = nz[15];
         sd1_in.neg_b = !nx[15] && (nx != 16'sd0);
      end else begin
         mag_b_in     = ay;
         sd1_in.neg_a = !nz[15] && (nz != 16'sd0);
         sd1_in.neg_b = ny[15];
      end
   end

   // Flag a zero denominator beside the sideband
   always_comb begin
      sd3_in       = sd2_ff;
      sd3_in.degen = ({1'b0, sq_a_ff} + {1'b0, sq_b_ff}) == 32'd0;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sd1_ff   <= sd1_in;
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
         // Stage 2: squares
         sd2_ff   <= sd1_ff;
         sq_a_ff  <= 31'(32'(mag_a_ff) * 32'(mag_a_ff));
         sq_b_ff  <= 31'(32'(mag_b_ff) * 32'(mag_b_ff));
         // Stage 3: denominator and scaled targets
         sd3_ff       <= sd3_in;
         den_ff       <= {1'b0, sq_a_ff} + {1'b0, sq_b_ff};
         tgt_a_ff     <= {3'b0, sq_a_ff, 30'b0};
         tgt_b_ff     <= {3'b0, sq_b_ff, 30'b0};
      end
   end

   // Stages 4 to 19: the two root lanes
   cbg_root_lane u_lane_a (
      .clock  (clock),
      .enable (enable),
      .target (tgt_a_ff),
      .denom  (den_ff),
      .root   (root_a)
   );

   cbg_root_lane u_lane_b (
      .clock  (clock),
      .enable (enable),
      .target (tgt_b_ff),
      .denom  (den_ff),
      .root   (root_b)
   );

   // Delay the sideband beside the lanes
   always_ff @(posedge clock) begin
      if (enable) begin
         sdr_ff[0] <= sd3_ff;
         for (int k = 1; k < ROOT_LAT; k++) begin
            sdr_ff[k] <= sdr_ff[k-1];
         end
      end
   end

   // Stage 20: round the root to the unit component and apply the sign; zero both for a degenerate normal
   always_comb begin
      logic [16:0] qa, qb;
      qa = ({1'b0, root_a} + 17'd1) >> 1;
      qb = ({1'b0, root_b} + 17'd1) >> 1;
      tan_a_in = sdr_ff[ROOT_LAT-1].neg_a ? -$signed(qa[15:0]) : $signed(qa[15:0]);
      tan_b_in = sdr_ff[ROOT_LAT-1].neg_b ? -$signed(qb[15:0]) : $signed(qb[15:0]);
      if (sdr_ff[ROOT_LAT-1].degen) begin
         tan_a_in = 16'sd0;
         tan_b_in = 16'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sd20_ff  <= sdr_ff[ROOT_LAT-1];
         tan_a_ff <= tan_a_in;
         tan_b_ff <= tan_b_in;
         // Stage 21: cross-product terms
         sd21_ff    <= sd20_ff;
         tan_a21_ff <= tan_a_ff;
         tan_b21_ff <= tan_b_ff;
         m0_ff      <= sd20_ff.ny * tan_b_ff;
         m1_ff      <= sd20_ff.nz * tan_a_ff;
         m2_ff      <= sd20_ff.nx * tan_b_ff;
         m3_ff      <= (sd20_ff.br_x ? sd20_ff.ny : sd20_ff.nx) * tan_a_ff;
         // Stage 22: combine the terms per branch
         sd22_ff    <= sd21_ff;
         tan_a22_ff <= tan_a21_ff;
         tan_b22_ff <= tan_b21_ff;
         if (sd21_ff.br_x) begin
            b0_ff <= 33'(m0_ff);
            b1_ff <= 33'(m1_ff) - 33'(m2_ff);
            b2_ff <= -33'(m3_ff);
         end else begin
            b0_ff <= 33'(m0_ff) - 33'(m1_ff);
            b1_ff <= -33'(m2_ff);
            b2_ff <= 33'(m3_ff);
         end
         // Stage 23: round, saturate and place the axes
         out_degen_ff <= sd22_ff.degen;
         if (sd22_ff.br_x) begin
            out_data_ff[47:0] <= {tan_b22_ff, 16'sd0, tan_a22_ff};
         end else begin
            out_data_ff[47:0] <= {tan_b22_ff, tan_a22_ff, 16'sd0};
         end
         out_data_ff[95:48] <= {to_q14(b2_ff), to_q14(b1_ff), to_q14(b0_ff)};
      end
   end

   assign rsp_tvalid = vld_ff[NSTAGE];
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_degen_ff;

   // A degenerate result carries all-zero axes
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 96'd0)
      else $error("degenerate result with non-zero axes");

   // Tangent x and z components stay within unit magnitude
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[15:0]) <= 16'sd16384
                  && $signed(rsp_tdata[15:0]) >= -16'sd16384
                  && $signed(rsp_tdata[47:32]) <= 16'sd16384
                  && $signed(rsp_tdata[47:32]) >= -16'sd16384)
      else $error("tangent component beyond unit range");

   // A stall freezes all stage valid bits
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

endmodule
